[hw/rtl/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types and constants of the utf-8 byte stream decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CP_W       = 21;
  localparam int unsigned USED_W     = 3;
  localparam int unsigned MAX_RESULT = 4;
  localparam int unsigned SLOT_W     = $clog2(MAX_RESULT);
  localparam int unsigned COUNT_W    = $clog2(MAX_RESULT + 1);
  localparam int unsigned TAIL_W     = 6;
  localparam int unsigned TAIL_DEPTH = 2;
  localparam int unsigned OUT_DATA_W = 24;

  // byte classes by top bits
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  // continuation bytes needed after a lead byte
  localparam logic [1:0] NEED_NONE = 2'd0;
  localparam logic [1:0] NEED_ONE  = 2'd1;
  localparam logic [1:0] NEED_TWO  = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  localparam logic [USED_W-1:0] USED_SINGLE = 3'd1;

  // results caused by one input byte, slot 0 goes out first
  typedef struct packed {
    logic [COUNT_W-1:0]                count;
    logic [MAX_RESULT-1:0][CP_W-1:0]   cp;
    logic [MAX_RESULT-1:0][USED_W-1:0] used;
  } utf8d_batch_t;

endpackage

[hw/rtl/utf8_byte_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_unit
// utf-8 byte stream to code point decoder
// ----------------------------------------------------------------------------
// input channel s_*: one text byte per request in s_tdata[7:0].
// output channel m_*: one result per request, code point in m_tdata[20:0],
// bytes accounted for in m_tdata[23:21]; m_tlast marks the last result
// caused by one input byte.
// a byte is held in an input register, decoded in one pass and its results
// (zero to four) land in the result buffer as soon as it is free, so the
// first result is valid once both the input register and the buffer have
// been written.
// one byte per cycle is taken while no byte yields more than one result and
// m_tready is high. a broken sequence yields up to four results, sent one
// per cycle while m_tready is high; input is held off until they drain.
// lead and continuation bytes of an open sequence give no result until the
// sequence completes.
// when the receiver stalls, the buffer holds its results and one more byte
// waits in the input register before s_tready drops.
// reset (synchronous, active high) empties both stages and closes any open
// sequence.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_unit
  import utf8d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] text_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [20:0] code_point, [23:21] bytes_used
  output logic                  m_tlast    // last_of_run
);

  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic              free;
  logic              move;
  utf8d_batch_t      batch;

  assign move     = in_full && free;
  assign s_tready = !in_full || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  utf8d_dec u_dec (
    .clk       (clk),
    .rst       (rst),
    .step      (move),
    .text_byte (in_byte),
    .batch     (batch)
  );

  utf8d_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (move),
    .batch    (batch),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

[hw/rtl/utf8d_dec.sv]
// ----------------------------------------------------------------------------
// utf8d_dec
// sequence state and combinational decode of one byte into a result batch
// ----------------------------------------------------------------------------
module utf8d_dec
  import utf8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] text_byte,
  output utf8d_batch_t      batch
);

  logic [BYTE_W-1:0] lead_byte, lead_byte_next;
  logic [TAIL_DEPTH-1:0][TAIL_W-1:0] tail_bytes;
  logic [1:0]        bytes_expected, bytes_expected_next;
  logic [1:0]        bytes_seen, bytes_seen_next;
  logic [CP_W-1:0]   partial_value, partial_value_next;

  logic              tail_we;
  logic [CP_W-1:0]   shifted;
  logic              is_cont;
  logic              broken;
  logic              pass;
  logic [COUNT_W-1:0] n_broken;

  assign is_cont = (text_byte[7:6] == CONT_TAG);
  assign broken  = (bytes_expected != NEED_NONE) && !is_cont;
  assign shifted = {partial_value[CP_W-7:0], text_byte[TAIL_W-1:0]};

  always_comb begin
    lead_byte_next      = lead_byte;
    bytes_expected_next = bytes_expected;
    bytes_seen_next     = bytes_seen;
    partial_value_next  = partial_value;
    tail_we             = 1'b0;
    pass                = 1'b0;
    n_broken            = '0;
    batch.count         = '0;
    for (int i = 0; i < MAX_RESULT; i++) begin
      batch.cp[i]   = '0;
      batch.used[i] = USED_SINGLE;
    end

    if ((bytes_expected != NEED_NONE) && is_cont) begin
      if ({1'b0, bytes_seen} + 3'd1 >= {1'b0, bytes_expected}) begin
        batch.count         = COUNT_W'(1);
        batch.cp[0]         = shifted;
        batch.used[0]       = {1'b0, bytes_expected} + 3'd1;
        bytes_expected_next = NEED_NONE;
        bytes_seen_next     = '0;
        partial_value_next  = '0;
      end else begin
        tail_we            = 1'b1;
        bytes_seen_next    = bytes_seen + 2'd1;
        partial_value_next = shifted;
      end
    end else begin
      if (broken) begin
        // replay lead byte and buffered continuation bytes
        n_broken            = COUNT_W'(1) + COUNT_W'(bytes_seen);
        batch.cp[0]         = CP_W'(lead_byte);
        batch.cp[1]         = CP_W'({CONT_TAG, tail_bytes[0]});
        batch.cp[2]         = CP_W'({CONT_TAG, tail_bytes[1]});
        bytes_expected_next = NEED_NONE;
        bytes_seen_next     = '0;
        partial_value_next  = '0;
      end
      if (text_byte[7:5] == LEAD2_TAG) begin
        lead_byte_next      = text_byte;
        partial_value_next  = CP_W'(text_byte[4:0]);
        bytes_expected_next = NEED_ONE;
      end else if (text_byte[7:4] == LEAD3_TAG) begin
        lead_byte_next      = text_byte;
        partial_value_next  = CP_W'(text_byte[3:0]);
        bytes_expected_next = NEED_TWO;
      end else if (text_byte[7:3] == LEAD4_TAG) begin
        lead_byte_next      = text_byte;
        partial_value_next  = CP_W'(text_byte[2:0]);
        bytes_expected_next = NEED_THREE;
      end else begin
        // ascii, stray continuation and invalid lead bytes
        pass = 1'b1;
      end
      if (pass) begin
        batch.cp[n_broken[SLOT_W-1:0]] = CP_W'(text_byte);
      end
      batch.count = n_broken + COUNT_W'(pass);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte      <= '0;
      bytes_expected <= NEED_NONE;
      bytes_seen     <= '0;
      partial_value  <= '0;
    end else if (step) begin
      lead_byte      <= lead_byte_next;
      bytes_expected <= bytes_expected_next;
      bytes_seen     <= bytes_seen_next;
      partial_value  <= partial_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && tail_we) begin
      tail_bytes[bytes_seen[0]] <= text_byte[TAIL_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_idle_no_seen: assert property (@(posedge clk) disable iff (rst)
    (bytes_expected == NEED_NONE) |-> (bytes_seen == 2'd0))
    else $error("continuation count set with no open sequence");

  a_seen_below_need: assert property (@(posedge clk) disable iff (rst)
    (bytes_expected != NEED_NONE) |-> (bytes_seen < bytes_expected))
    else $error("continuation count reached sequence length");

  a_lead_opens: assert property (@(posedge clk) disable iff (rst)
    step && (batch.count == '0) |=> (bytes_expected != NEED_NONE))
    else $error("byte without result left no sequence open");
`endif

endmodule

[hw/rtl/utf8d_out.sv]
// ----------------------------------------------------------------------------
// utf8d_out
// result buffer, sends one batch out one result per cycle unless stalled
// ----------------------------------------------------------------------------
module utf8d_out
  import utf8d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  utf8d_batch_t          batch,
  output logic                  free,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  logic [MAX_RESULT-1:0][CP_W-1:0]   cp_buf;
  logic [MAX_RESULT-1:0][USED_W-1:0] used_buf;
  logic [COUNT_W-1:0]                remain;
  logic [SLOT_W-1:0]                 pos;
  logic                              take;

  assign m_tvalid = (remain != '0);
  assign m_tlast  = (remain == COUNT_W'(1));
  assign take     = m_tvalid && m_tready;
  assign free     = (remain == '0) || (m_tlast && m_tready);
  assign m_tdata  = {used_buf[pos], cp_buf[pos]};

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
      pos    <= '0;
    end else if (load && free) begin
      remain <= batch.count;
      pos    <= '0;
    end else if (take) begin
      remain <= remain - COUNT_W'(1);
      pos    <= pos + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      cp_buf   <= batch.cp;
      used_buf <= batch.used;
    end
  end

`ifndef SYNTHESIS
  a_remain_range: assert property (@(posedge clk) disable iff (rst)
    remain <= COUNT_W'(MAX_RESULT))
    else $error("result count out of range");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load && free |=> (remain == $past(batch.count)) && (pos == '0))
    else $error("batch not loaded as requested");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while the receiver stalled");
`endif

endmodule

[tb/utf8_byte_stream_decoder_unit_test.sv]
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_unit_test
// self-checking bench for the utf-8 byte stream decoder
// ----------------------------------------------------------------------------
// text bytes go in as stream requests and every decoded result coming out is
// checked field by field against a cycle-free decoder model kept in the
// bench. a short table of directed bytes hits the pass-through extremes,
// every sequence length and broken sequences; random well-formed text,
// broken sequences and noise follow. both sides idle at random, with quiet
// stretches; the sender lets all results drain after the table and midway.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_unit_test;
  import utf8d_pkg::*;

  localparam int RANDOM_BYTES   = 455;
  localparam int MAX_IDLE       = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [CP_W-1:0]   cp;
    logic [USED_W-1:0] used;
    logic              last;
  } cp_result_t;

  // typed rows carry a single pass-through result read straight off the byte
  typedef struct packed {
    logic              typed;
    logic [BYTE_W-1:0] text;
    logic [CP_W-1:0]   cp;
  } text_row_t;

  localparam text_row_t DIRECTED_ROWS [25] = '{
    {1'b1, 8'h00, 21'h000000},
    {1'b1, 8'h7F, 21'h00007F},
    {1'b1, 8'h80, 21'h000080},  // stray continuation bytes
    {1'b1, 8'hBF, 21'h0000BF},
    {1'b1, 8'hF8, 21'h0000F8},  // bytes that cannot start a sequence
    {1'b1, 8'hFF, 21'h0000FF},
    {1'b0, 8'hC2, 21'h0},
    {1'b0, 8'h80, 21'h0},
    {1'b0, 8'hDF, 21'h0},
    {1'b0, 8'hBF, 21'h0},
    {1'b0, 8'hE0, 21'h0},       // overlong three-byte zero
    {1'b0, 8'h80, 21'h0},
    {1'b0, 8'h80, 21'h0},
    {1'b0, 8'hF7, 21'h0},       // largest four-byte value
    {1'b0, 8'hBF, 21'h0},
    {1'b0, 8'hBF, 21'h0},
    {1'b0, 8'hBF, 21'h0},
    {1'b0, 8'hF4, 21'h0},       // broken after two tails, four results
    {1'b0, 8'h80, 21'h0},
    {1'b0, 8'h80, 21'h0},
    {1'b0, 8'h41, 21'h0},
    {1'b0, 8'hC0, 21'h0},       // lead broken by another lead
    {1'b0, 8'hE1, 21'h0},
    {1'b0, 8'h80, 21'h0},
    {1'b0, 8'hFF, 21'h0}
  };

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata;   // [7:0] text_byte
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [20:0] code_point, [23:21] bytes_used
  logic                  m_tlast;   // last_of_run

  // decoder model state
  logic [BYTE_W-1:0] lead_q    = '0;
  logic [TAIL_W-1:0] tail_q [TAIL_DEPTH];
  logic [1:0]        need_q    = NEED_NONE;
  logic [1:0]        seen_q    = '0;
  logic [CP_W-1:0]   partial_q = '0;

  cp_result_t step_out [$];
  cp_result_t cp_expect_q [$];
  text_row_t  row_tag_q [$];

  int  errors        = 0;
  int  bytes_in      = 0;
  int  results_out   = 0;
  int  replay_runs   = 0;
  int  idle_cycles   = 0;
  bit  quiet_tx      = 1'b0;
  bit  quiet_rx      = 1'b0;

  utf8_byte_stream_decoder_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic emit_cp(input logic [CP_W-1:0] cp, input logic [USED_W-1:0] used);
    cp_result_t r;
    r.cp   = cp;
    r.used = used;
    r.last = 1'b0;
    step_out.push_back(r);
  endtask

  task automatic close_sequence();
    need_q    = NEED_NONE;
    seen_q    = '0;
    partial_q = '0;
  endtask

  // decode one text byte into step_out, advancing the model state
  task automatic decode_text_byte(input logic [BYTE_W-1:0] b);
    step_out.delete();
    if (need_q != NEED_NONE) begin
      if (b[7:6] == CONT_TAG) begin
        partial_q = {partial_q[CP_W-7:0], b[5:0]};
        if (int'(seen_q) + 1 >= int'(need_q)) begin
          emit_cp(partial_q, USED_W'(need_q) + 3'd1);
          step_out[0].last = 1'b1;
          close_sequence();
          return;
        end
        tail_q[seen_q[0]] = b[5:0];
        seen_q = seen_q + 2'd1;
        return;
      end
      // broken sequence: replay lead and buffered tails as raw bytes
      replay_runs++;
      emit_cp(CP_W'(lead_q), USED_SINGLE);
      for (int k = 0; k < int'(seen_q) && k < TAIL_DEPTH; k++)
        emit_cp(CP_W'({CONT_TAG, tail_q[k]}), USED_SINGLE);
      close_sequence();
    end
    if (b[7] == 1'b0) begin
      emit_cp(CP_W'(b), USED_SINGLE);
    end else if (b[7:5] == LEAD2_TAG) begin
      lead_q    = b;
      partial_q = CP_W'(b[4:0]);
      need_q    = NEED_ONE;
    end else if (b[7:4] == LEAD3_TAG) begin
      lead_q    = b;
      partial_q = CP_W'(b[3:0]);
      need_q    = NEED_TWO;
    end else if (b[7:3] == LEAD4_TAG) begin
      lead_q    = b;
      partial_q = CP_W'(b[2:0]);
      need_q    = NEED_THREE;
    end else begin
      emit_cp(CP_W'(b), USED_SINGLE);
    end
    if (step_out.size() > 0)
      step_out[step_out.size()-1].last = 1'b1;
  endtask

  // request monitor: both channels sampled at the rising edge
  always @(posedge clk) begin : monitor
    cp_result_t got;
    cp_result_t want;
    text_row_t  tag;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (m_tvalid && m_tready) begin
        got.cp   = m_tdata[CP_W-1:0];
        got.used = m_tdata[CP_W +: USED_W];
        got.last = m_tlast;
        results_out++;
        if (cp_expect_q.size() == 0) begin
          $display("%0t: unexpected result cp=%h used=%0d last=%b",
                   $time, got.cp, got.used, got.last);
          errors++;
        end else begin
          want = cp_expect_q.pop_front();
          if (got.cp !== want.cp) begin
            $display("%0t: code_point expected %h got %h", $time, want.cp, got.cp);
            errors++;
          end
          if (got.used !== want.used) begin
            $display("%0t: bytes_used expected %0d got %0d", $time, want.used, got.used);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_of_run expected %b got %b", $time, want.last, got.last);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        bytes_in++;
        tag = row_tag_q.pop_front();
        decode_text_byte(s_tdata);
        if (tag.typed) begin
          want.cp   = tag.cp;
          want.used = USED_SINGLE;
          want.last = 1'b1;
          cp_expect_q.push_back(want);
        end else begin
          foreach (step_out[i]) cp_expect_q.push_back(step_out[i]);
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall before each result, quiet stretches now and then
  initial begin : receiver
    int gap;
    int taken;
    m_tready = 1'b0;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 50 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
      gap = quiet_rx ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  // one byte request; entered and left at a falling edge
  task automatic send_row(input text_row_t row);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    row_tag_q.push_back(row);
    s_tvalid <= 1'b1;
    s_tdata  <= row.text;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    wait (cp_expect_q.size() == 0);
    @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] lead_for(input int len);
    case (len)
      2:       lead_for = {LEAD2_TAG, 5'($urandom)};
      3:       lead_for = {LEAD3_TAG, 4'($urandom)};
      4:       lead_for = {LEAD4_TAG, 3'($urandom)};
      default: lead_for = BYTE_W'($urandom_range(0, 127));
    endcase
  endfunction

  initial begin : stimulus
    logic [BYTE_W-1:0] seq_bytes [$];
    logic [BYTE_W-1:0] b;
    text_row_t         row;
    int                kind;
    int                len;
    int                n_tail;
    int                random_sent;
    int                next_switch;
    bit                paused;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) send_row(DIRECTED_ROWS[i]);
    hold_until_drained();

    random_sent = 0;
    next_switch = 0;
    paused      = 1'b0;
    while (random_sent < RANDOM_BYTES) begin
      if (random_sent >= next_switch) begin
        quiet_tx    = ($urandom_range(0, 3) == 0);
        next_switch = random_sent + 60;
      end
      seq_bytes.delete();
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        // well-formed character
        len = $urandom_range(1, 4);
        seq_bytes.push_back(lead_for(len));
        for (int k = 1; k < len; k++) seq_bytes.push_back({CONT_TAG, 6'($urandom)});
      end else if (kind <= 7) begin
        // sequence cut short by a byte that is not a continuation
        len    = $urandom_range(2, 4);
        n_tail = $urandom_range(0, len - 2);
        seq_bytes.push_back(lead_for(len));
        for (int k = 0; k < n_tail; k++) seq_bytes.push_back({CONT_TAG, 6'($urandom)});
        b = BYTE_W'($urandom_range(0, 255));
        if (b[7:6] == CONT_TAG) b[6] = 1'b1;
        seq_bytes.push_back(b);
      end else begin
        seq_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      end
      foreach (seq_bytes[i]) begin
        row = {1'b0, seq_bytes[i], {CP_W{1'b0}}};
        send_row(row);
        random_sent++;
      end
      if (!paused && random_sent >= RANDOM_BYTES / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
    s_tvalid <= 1'b0;

    wait (cp_expect_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("decoded %0d text bytes into %0d checked results", bytes_in, results_out);
    $display("%0d broken sequences replayed as raw bytes", replay_runs);
    if (errors == 0 && cp_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
